/* sv/qas_pkg.sv */
// Shared types and constants for the quoted argument splitter.
`timescale 1ns / 1ps
`default_nettype none

package qas_pkg;

    localparam int unsigned SLOTS_W   = 9;
    localparam logic [SLOTS_W-1:0] SLOT_CAP = 9'd256;
    localparam int unsigned OUT_DEPTH = 4;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DQ    = 8'h22;
    localparam logic [7:0] CH_SQ    = 8'h27;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_T     = 8'h74;

    typedef enum logic [1:0] {
        KIND_BYTE = 2'd0,
        KIND_END  = 2'd1,
        KIND_DONE = 2'd2,
        KIND_OVF  = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] out_byte;
        logic [7:0] arg_index;
        logic       first_of_arg;
        logic [7:0] arg_count;
        logic       last;
    } result_t;

    localparam result_t RESULT_NONE = '{
        kind: KIND_BYTE, out_byte: 8'd0, arg_index: 8'd0,
        first_of_arg: 1'b0, arg_count: 8'd0, last: 1'b0
    };

endpackage

`default_nettype wire

/* sv/qas_parser.sv */
// Tokenizer state and per-byte result generation (up to two results per byte).
`timescale 1ns / 1ps
`default_nettype none

module qas_parser (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    input  wire                                 cfg_wr_en,
    input  wire  [qas_pkg::SLOTS_W-1:0]         cfg_wr_data,
    input  wire                                 in_vld,
    input  wire  [7:0]                          in_char,
    output logic                                res0_vld,
    output qas_pkg::result_t                    res0,
    output logic                                res1_vld,
    output qas_pkg::result_t                    res1
);

    logic [qas_pkg::SLOTS_W-1:0] slots_reg;
    logic       in_arg_reg, in_arg_next;
    logic       sq_reg, sq_next;
    logic       dq_reg, dq_next;
    logic       esc_reg, esc_next;
    logic [7:0] cnt_reg, cnt_next;
    logic       ovf_reg, ovf_next;

    logic [qas_pkg::SLOTS_W-1:0] limit;
    logic       add;
    logic       is_ws;
    logic [7:0] ch;

    assign limit = (slots_reg > qas_pkg::SLOT_CAP) ? qas_pkg::SLOT_CAP : slots_reg;
    assign is_ws = (in_char == qas_pkg::CH_SPACE) || (in_char == qas_pkg::CH_TAB) ||
                   (in_char == qas_pkg::CH_LF) || (in_char == qas_pkg::CH_CR);

    function automatic qas_pkg::result_t mk(input qas_pkg::kind_t k, input logic [7:0] b,
                                            input logic [7:0] idx, input logic f,
                                            input logic [7:0] c, input logic l);
        qas_pkg::result_t r;
        r.kind         = k;
        r.out_byte     = b;
        r.arg_index    = idx;
        r.first_of_arg = f;
        r.arg_count    = c;
        r.last         = l;
        return r;
    endfunction

    always_comb begin
        in_arg_next = in_arg_reg;
        sq_next     = sq_reg;
        dq_next     = dq_reg;
        esc_next    = esc_reg;
        cnt_next    = cnt_reg;
        ovf_next    = ovf_reg;
        add         = 1'b0;
        ch          = in_char;
        res0_vld    = 1'b0;
        res1_vld    = 1'b0;
        res0        = qas_pkg::RESULT_NONE;
        res1        = qas_pkg::RESULT_NONE;

        if (in_vld) begin
            if (in_char == qas_pkg::CH_NUL) begin
                // terminator: close open argument, report count, clear parse state
                res0_vld = 1'b1;
                if (!ovf_reg && in_arg_reg && (cnt_reg != 8'd0)) begin
                    res0 = mk(qas_pkg::KIND_END, 8'd0, cnt_reg - 8'd1, 1'b0, cnt_reg, 1'b0);
                    res1_vld = 1'b1;
                    res1 = mk(qas_pkg::KIND_DONE, 8'd0, 8'd0, 1'b0, cnt_reg, 1'b1);
                end else begin
                    res0 = mk(qas_pkg::KIND_DONE, 8'd0, 8'd0, 1'b0, cnt_reg, 1'b1);
                end
                in_arg_next = 1'b0;
                sq_next     = 1'b0;
                dq_next     = 1'b0;
                esc_next    = 1'b0;
                cnt_next    = 8'd0;
                ovf_next    = 1'b0;
            end else if (!ovf_reg) begin
                if (esc_reg) begin
                    esc_next = 1'b0;
                    add      = 1'b1;
                    if (in_char == qas_pkg::CH_N) ch = qas_pkg::CH_LF;
                    else if (in_char == qas_pkg::CH_T) ch = qas_pkg::CH_TAB;
                    else if (in_char == qas_pkg::CH_R) ch = qas_pkg::CH_CR;
                end else if (in_char == qas_pkg::CH_BSL) begin
                    esc_next = 1'b1;
                end else if (in_char == qas_pkg::CH_SQ) begin
                    if (dq_reg) add = 1'b1;
                    else        sq_next = !sq_reg;
                end else if (in_char == qas_pkg::CH_DQ) begin
                    if (sq_reg) add = 1'b1;
                    else        dq_next = !dq_reg;
                end else if (is_ws) begin
                    if (in_arg_reg) begin
                        if (sq_reg || dq_reg) begin
                            add = 1'b1;
                        end else begin
                            in_arg_next = 1'b0;
                            if (cnt_reg != 8'd0) begin
                                res0_vld = 1'b1;
                                res0 = mk(qas_pkg::KIND_END, 8'd0, cnt_reg - 8'd1, 1'b0,
                                          cnt_reg, 1'b1);
                            end
                        end
                    end
                end else begin
                    add = 1'b1;
                end

                if (add) begin
                    if (!in_arg_reg) begin
                        if (({1'b0, cnt_reg} + 9'd1) < limit) begin
                            cnt_next    = cnt_reg + 8'd1;
                            in_arg_next = 1'b1;
                            res0_vld    = 1'b1;
                            res0 = mk(qas_pkg::KIND_BYTE, ch, cnt_reg, 1'b1,
                                      cnt_reg + 8'd1, 1'b1);
                        end else begin
                            ovf_next = 1'b1;
                            res0_vld = 1'b1;
                            res0 = mk(qas_pkg::KIND_OVF, 8'd0, 8'd0, 1'b0, cnt_reg, 1'b1);
                        end
                    end else if (cnt_reg != 8'd0) begin
                        res0_vld = 1'b1;
                        res0 = mk(qas_pkg::KIND_BYTE, ch, cnt_reg - 8'd1, 1'b0, cnt_reg, 1'b1);
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slots_reg  <= qas_pkg::SLOT_CAP;
            in_arg_reg <= 1'b0;
            sq_reg     <= 1'b0;
            dq_reg     <= 1'b0;
            esc_reg    <= 1'b0;
            cnt_reg    <= 8'd0;
            ovf_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) slots_reg <= cfg_wr_data;
            in_arg_reg <= in_arg_next;
            sq_reg     <= sq_next;
            dq_reg     <= dq_next;
            esc_reg    <= esc_next;
            cnt_reg    <= cnt_next;
            ovf_reg    <= ovf_next;
        end
    end

    a_arg_has_count: assert property (@(posedge aclk) disable iff (!aresetn)
        in_arg_reg |-> (cnt_reg != 8'd0))
        else $error("open argument with zero count");

    a_second_is_done: assert property (@(posedge aclk) disable iff (!aresetn)
        res1_vld |-> (res0_vld && (res1.kind == qas_pkg::KIND_DONE) &&
                      (res0.kind == qas_pkg::KIND_END)))
        else $error("second result must be end followed by done");

    a_term_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_vld && (in_char == qas_pkg::CH_NUL)) |=>
            (!in_arg_reg && !ovf_reg && !esc_reg && (cnt_reg == 8'd0)))
        else $error("terminator did not clear parse state");

endmodule

`default_nettype wire

/* sv/qas_out_fifo.sv */
// Result queue: takes up to two results per cycle, delivers one per transfer.
`timescale 1ns / 1ps
`default_nettype none

module qas_out_fifo #(
    parameter int unsigned DEPTH = qas_pkg::OUT_DEPTH
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 push0,
    input  qas_pkg::result_t    din0,
    input  wire                 push1,
    input  qas_pkg::result_t    din1,
    output logic                room2,
    output logic                out_vld,
    input  wire                 out_rdy,
    output qas_pkg::result_t    dout
);

    // DEPTH must be a power of two, at least 2
    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] ROOM_MAX = CNT_W'(DEPTH - 2);

    qas_pkg::result_t mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             pop;

    assign out_vld = (cnt_reg != '0);
    assign dout    = mem_reg[rd_ptr_reg];
    assign pop     = out_vld && out_rdy;
    assign room2   = (cnt_reg <= ROOM_MAX);

    always_comb begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push0) + PTR_W'(push1);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        cnt_next    = cnt_reg + CNT_W'(push0) + CNT_W'(push1) - CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push0) mem_reg[wr_ptr_reg] <= din0;
        if (push1) mem_reg[wr_ptr_reg + PTR_W'(1)] <= din1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(DEPTH))
        else $error("result queue count out of range");

    a_push_order: assert property (@(posedge aclk) disable iff (!aresetn)
        push1 |-> push0)
        else $error("second slot written without first");

    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        push0 |-> room2)
        else $error("push into full result queue");

endmodule

`default_nettype wire

/* sv/quoted_argument_splitter.sv */
// A result is written into the result queue as its byte transfers and is then offered
// on the master side from the queue head. Throughput: one byte per cycle while
// s_axis_tready is high; a terminator that closes an open argument queues two results
// (argument end and done), so the result queue (OUT_DEPTH entries) sets how long a
// stalled master side can be absorbed before s_axis_tready drops. Reset: synchronous
// active-low aresetn clears parse state and the queue; max_slots returns to 256.
`timescale 1ns / 1ps
`default_nettype none

module quoted_argument_splitter #(
    parameter int unsigned OUT_DEPTH = qas_pkg::OUT_DEPTH
) (
    input  wire                             aclk,
    input  wire                             aresetn,
    input  wire                             cfg_wr_en,
    input  wire  [qas_pkg::SLOTS_W-1:0]     cfg_wr_data,   // max_slots
    input  wire                             s_axis_tvalid,
    output logic                            s_axis_tready,
    input  wire  [7:0]                      s_axis_tdata,  // [7:0] char_in
    output logic                            m_axis_tvalid,
    input  wire                             m_axis_tready,
    output logic [23:0]                     m_axis_tdata,  // [7:0] out_byte, [15:8] arg_index,
                                                           // [23:16] arg_count
    output logic [2:0]                      m_axis_tuser,  // [1:0] kind, [2] first_of_arg
    output logic                            m_axis_tlast   // last
);

    logic             in_xfer;
    logic             res0_vld, res1_vld;
    qas_pkg::result_t res0, res1, head;

    assign in_xfer = s_axis_tvalid && s_axis_tready;

    qas_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_vld      (in_xfer),
        .in_char     (s_axis_tdata),
        .res0_vld    (res0_vld),
        .res0        (res0),
        .res1_vld    (res1_vld),
        .res1        (res1)
    );

    qas_out_fifo #(
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push0   (res0_vld),
        .din0    (res0),
        .push1   (res1_vld),
        .din1    (res1),
        .room2   (s_axis_tready),
        .out_vld (m_axis_tvalid),
        .out_rdy (m_axis_tready),
        .dout    (head)
    );

    assign m_axis_tdata = {head.arg_count, head.arg_index, head.out_byte};
    assign m_axis_tuser = {head.first_of_arg, head.kind};
    assign m_axis_tlast = head.last;

endmodule

`default_nettype wire

/* tb/sv/tb.sv */
// Self-checking testbench for quoted_argument_splitter: predicts every token and compares.
`timescale 1ns / 1ps

module tb;

    localparam int SETTLE_CYCLES = 4;
    localparam int HOLD_CYCLES   = 64;
    localparam int RANDOM_BYTES  = 300;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        cfg_wr_en     = 1'b0;
    logic [8:0]  cfg_wr_data   = '0;
    logic        s_axis_tvalid = 1'b0;
    logic [7:0]  s_axis_tdata  = '0;
    logic        m_axis_tready = 1'b0;
    logic        s_axis_tready;
    logic        m_axis_tvalid;
    logic [23:0] m_axis_tdata;   // [7:0] out_byte, [15:8] arg_index, [23:16] arg_count
    logic [2:0]  m_axis_tuser;   // [1:0] kind, [2] first_of_arg
    logic        m_axis_tlast;   // last

    quoted_argument_splitter dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // tokenizer shadow state
    logic [8:0] slot_reg = qas_pkg::SLOT_CAP;
    bit         in_arg, in_sq, in_dq, esc_pending, ovf_set;
    logic [7:0] arg_total;

    qas_pkg::result_t token_q[$];

    int  mismatches    = 0;
    int  live_bytes    = 0;
    int  commands_sent = 0;
    int  tokens_seen   = 0;
    int  ovf_seen      = 0;
    int  top_index     = 0;
    bit  calm          = 1'b0;
    bit  hold_req      = 1'b0;

    function automatic qas_pkg::result_t make_result(qas_pkg::kind_t k, logic [7:0] b,
                                                     logic [7:0] idx, logic first,
                                                     logic [7:0] cnt);
        qas_pkg::result_t r;
        r.kind         = k;
        r.out_byte     = b;
        r.arg_index    = idx;
        r.first_of_arg = first;
        r.arg_count    = cnt;
        r.last         = 1'b0;
        return r;
    endfunction

    // Advance the shadow tokenizer by one byte and queue the tokens it yields.
    function automatic void tokenize_char(logic [7:0] c_in);
        qas_pkg::result_t r [2];
        int               n;
        int               cap;
        logic [7:0]       c;
        bit               add;
        bit               first;
        n     = 0;
        c     = c_in;
        add   = 1'b0;
        first = 1'b0;
        cap   = (slot_reg > qas_pkg::SLOT_CAP) ? int'(qas_pkg::SLOT_CAP) : int'(slot_reg);
        if (c == qas_pkg::CH_NUL || !ovf_set)
            live_bytes++;

        if (c == qas_pkg::CH_NUL) begin
            if (!ovf_set && in_arg && arg_total > 0) begin
                r[n] = make_result(qas_pkg::KIND_END, 8'd0, arg_total - 8'd1, 1'b0,
                                   arg_total);
                n++;
            end
            r[n] = make_result(qas_pkg::KIND_DONE, 8'd0, 8'd0, 1'b0, arg_total);
            n++;
            in_arg      = 1'b0;
            in_sq       = 1'b0;
            in_dq       = 1'b0;
            esc_pending = 1'b0;
            ovf_set     = 1'b0;
            arg_total   = 8'd0;
            commands_sent++;
        end else if (!ovf_set) begin
            if (esc_pending) begin
                esc_pending = 1'b0;
                if (c == qas_pkg::CH_N)      c = qas_pkg::CH_LF;
                else if (c == qas_pkg::CH_T) c = qas_pkg::CH_TAB;
                else if (c == qas_pkg::CH_R) c = qas_pkg::CH_CR;
                add = 1'b1;
            end else if (c == qas_pkg::CH_BSL) begin
                esc_pending = 1'b1;
            end else if (c == qas_pkg::CH_SQ) begin
                if (in_dq) add = 1'b1;
                else       in_sq = !in_sq;
            end else if (c == qas_pkg::CH_DQ) begin
                if (in_sq) add = 1'b1;
                else       in_dq = !in_dq;
            end else if (c == qas_pkg::CH_SPACE || c == qas_pkg::CH_TAB ||
                         c == qas_pkg::CH_LF || c == qas_pkg::CH_CR) begin
                if (in_arg) begin
                    if (in_sq || in_dq) begin
                        add = 1'b1;
                    end else begin
                        in_arg = 1'b0;
                        if (arg_total > 0) begin
                            r[n] = make_result(qas_pkg::KIND_END, 8'd0, arg_total - 8'd1,
                                               1'b0, arg_total);
                            n++;
                        end
                    end
                end
            end else begin
                add = 1'b1;
            end

            if (add && !in_arg) begin
                if (int'(arg_total) + 1 < cap) begin
                    arg_total = arg_total + 8'd1;
                    in_arg    = 1'b1;
                    first     = 1'b1;
                end else begin
                    // slot limit hit: report once, swallow the rest of the string
                    ovf_set = 1'b1;
                    add     = 1'b0;
                    r[n] = make_result(qas_pkg::KIND_OVF, 8'd0, 8'd0, 1'b0, arg_total);
                    n++;
                end
            end
            if (add && arg_total > 0) begin
                r[n] = make_result(qas_pkg::KIND_BYTE, c, arg_total - 8'd1, first,
                                   arg_total);
                n++;
            end
        end

        for (int i = 0; i < n; i++) begin
            r[i].last = (i == n - 1);
            token_q.insert(token_q.size(), r[i]);
        end
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge aclk) begin : check_tokens
        qas_pkg::result_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            tokens_seen++;
            if (m_axis_tuser[1:0] == qas_pkg::KIND_OVF)
                ovf_seen++;
            if (int'(m_axis_tdata[15:8]) > top_index)
                top_index = int'(m_axis_tdata[15:8]);
            if (token_q.size() == 0) begin
                $error("unexpected result transfer: kind %0d byte %0d",
                       m_axis_tuser[1:0], m_axis_tdata[7:0]);
                mismatches++;
            end else begin
                want = token_q.pop_front();
                check_field("kind", int'(want.kind), int'(m_axis_tuser[1:0]));
                check_field("out_byte", int'(want.out_byte), int'(m_axis_tdata[7:0]));
                check_field("arg_index", int'(want.arg_index), int'(m_axis_tdata[15:8]));
                check_field("first_of_arg", int'(want.first_of_arg), int'(m_axis_tuser[2]));
                check_field("arg_count", int'(want.arg_count), int'(m_axis_tdata[23:16]));
                check_field("last", int'(want.last), int'(m_axis_tlast));
            end
        end
    end

    // Result side pacing: random stall bursts, plus one long hold-off on request.
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge aclk);
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 6) - 1) @(posedge aclk);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic send_char(input logic [7:0] c);
        if (!calm && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        do @(posedge aclk); while (!s_axis_tready);
        tokenize_char(c);
    endtask

    // Sends the text followed by the terminator.
    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i]);
        send_char(qas_pkg::CH_NUL);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (token_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_slots(input logic [8:0] v);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        slot_reg = v;
        cfg_wr_en <= 1'b0;
    endtask

    task automatic test_quoting_rules();
        // empty quote pairs start nothing, then a plain word
        send_text("\"\"''a");
        // escaped n, space and dquote; dquote and space inside single quotes;
        // lone backslash right before the terminator
        send_text("\\n\\ \\\"'\" x'\\");
        // whitespace inside quotes ahead of any byte is skipped; quote left open
        send_text("\" \tq");
    endtask

    task automatic test_slot_extremes();
        write_slots(9'd0);
        send_text("a");
        write_slots(9'd1);
        send_text(" x");
        write_slots(9'd2);
        send_text("a b");
    endtask

    // 33 slots: 32 arguments fit, the 33rd overflows and the rest is ignored.
    task automatic test_arg_limit();
        write_slots(9'd33);
        for (int i = 0; i < 33; i++) begin
            send_char(8'($urandom_range(8'h61, 8'h7A)));
            send_char(qas_pkg::CH_SPACE);
        end
        send_char(8'hFF);
        send_char(qas_pkg::CH_NUL);
        write_slots(qas_pkg::SLOT_CAP);
    endtask

    task automatic test_output_stall();
        calm     = 1'b1;
        hold_req = 1'b1;
        for (int i = 0; i < 40; i++)
            send_char((i % 4 == 3) ? qas_pkg::CH_SPACE : 8'($urandom_range(8'h30, 8'h39)));
        send_char(qas_pkg::CH_NUL);
        drain();
        calm = 1'b0;
    endtask

    function automatic logic [7:0] escape_target();
        case ($urandom_range(0, 7))
            0:       return qas_pkg::CH_N;
            1:       return qas_pkg::CH_T;
            2:       return qas_pkg::CH_R;
            3:       return qas_pkg::CH_SPACE;
            4:       return qas_pkg::CH_SQ;
            5:       return qas_pkg::CH_DQ;
            6:       return qas_pkg::CH_BSL;
            default: return 8'($urandom_range(1, 255));
        endcase
    endfunction

    task automatic send_random_command(input bit noisy);
        int         len;
        logic [7:0] q;
        len = $urandom_range(0, 24);
        for (int i = 0; i < len; i++) begin
            if (noisy) begin
                send_char(8'($urandom_range(1, 255)));
            end else begin
                case ($urandom_range(0, 19))
                    0, 1, 2, 3, 4, 5, 6, 7:
                        send_char(8'($urandom_range(8'h61, 8'h7A)));
                    8:  send_char(8'($urandom_range(1, 255)));
                    9, 10, 11:
                        send_char(qas_pkg::CH_SPACE);
                    12: begin
                        case ($urandom_range(0, 2))
                            0:       send_char(qas_pkg::CH_TAB);
                            1:       send_char(qas_pkg::CH_CR);
                            default: send_char(qas_pkg::CH_LF);
                        endcase
                    end
                    13, 14: begin
                        q = ($urandom_range(0, 1) == 0) ? qas_pkg::CH_SQ : qas_pkg::CH_DQ;
                        send_char(q);
                        repeat ($urandom_range(0, 3)) begin
                            case ($urandom_range(0, 3))
                                0:       send_char(qas_pkg::CH_SPACE);
                                1:       send_char((q == qas_pkg::CH_SQ) ?
                                                   qas_pkg::CH_DQ : qas_pkg::CH_SQ);
                                default: send_char(8'($urandom_range(8'h41, 8'h5A)));
                            endcase
                        end
                        send_char(q);
                    end
                    15: begin
                        send_char(qas_pkg::CH_BSL);
                        send_char(escape_target());
                    end
                    default: send_char(8'($urandom_range(8'h30, 8'h39)));
                endcase
            end
        end
        if (noisy && $urandom_range(0, 1) == 0)
            send_char(qas_pkg::CH_BSL);
        send_char(qas_pkg::CH_NUL);
    endtask

    task automatic test_random_commands();
        int start;
        int strings;
        start   = live_bytes;
        strings = 0;
        while (live_bytes - start < RANDOM_BYTES) begin
            if (strings % 8 == 7) begin
                case ($urandom_range(0, 5))
                    0:       write_slots(9'($urandom_range(2, 4)));
                    1:       write_slots(9'($urandom_range(2, 256)));
                    2:       write_slots(qas_pkg::SLOT_CAP);
                    3:       write_slots(9'($urandom_range(257, 511)));
                    default: write_slots(9'($urandom_range(5, 12)));
                endcase
            end
            // tail of the run goes without idling on either side
            if (live_bytes - start > RANDOM_BYTES - 80)
                calm = 1'b1;
            send_random_command($urandom_range(0, 7) == 0);
            strings++;
        end
    endtask

    initial begin
        in_arg      = 1'b0;
        in_sq       = 1'b0;
        in_dq       = 1'b0;
        esc_pending = 1'b0;
        ovf_set     = 1'b0;
        arg_total   = 8'd0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_quoting_rules();
        test_slot_extremes();
        test_arg_limit();
        test_output_stall();
        test_random_commands();

        drain();
        repeat (8) @(posedge aclk);
        $display("Sent %0d live bytes over %0d command strings; %0d result transfers checked.",
                 live_bytes, commands_sent, tokens_seen);
        $display("Highest argument index %0d, %0d slot overflows reported.",
                 top_index, ovf_seen);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("timeout: %0d results still outstanding", token_q.size());
        $display("Mismatches found");
        $finish;
    end

endmodule
